>>> rtl/chm_pkg.sv
package chm_pkg;

   localparam int Buckets    = 1024;
   localparam int PoolNodes  = 4096;
   localparam int KeyBits    = 32;
   localparam int ValueBits  = 32;
   localparam int BucketBits = $clog2(Buckets);
   localparam int NodeBits   = $clog2(PoolNodes);
   localparam int RefBits    = NodeBits + 1;
   localparam int CountBits  = 11;
   localparam int QueueDepth = 2;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_TOUCH  = 2'd2;

   typedef struct packed {
      logic [1:0]           mode;
      logic [KeyBits-1:0]   key;
      logic [ValueBits-1:0] value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [ValueBits-1:0] value_out;
      logic                 pool_full;
      logic [12:0]          entry_count;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [1:0]            mode;
      logic [KeyBits-1:0]    key;
      logic [ValueBits-1:0]  value;
      logic [BucketBits-1:0] bucket;
   } job_type;

endpackage

>>> rtl/chm_front.sv
// Bucket selection: key mod bucket count by restoring division, one quotient
// bit per cycle.
module chm_front import chm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic [CountBits-1:0] csr_count,
   output logic                 job_valid,
   input  logic                 job_stall,
   output job_type              job_data
);

   localparam int StepBits = $clog2(KeyBits + 1);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_DONE} fstate_type;

   fstate_type               state_ff;
   req_type                  item_ff;
   logic [KeyBits-1:0]       rem_ff;
   logic [StepBits-1:0]      step_ff;
   logic [CountBits-1:0]     div_ff;
   logic [KeyBits:0]         shifted_in;
   logic [CountBits-1:0]     eff_count_in;

   always_comb begin
      if (csr_count == '0) begin
         eff_count_in = CountBits'(1);
      end else if (32'(csr_count) > Buckets) begin
         eff_count_in = CountBits'(Buckets);
      end else begin
         eff_count_in = csr_count;
      end
      shifted_in = {rem_ff, item_ff.key[KeyBits - 1 - 32'(step_ff)]};
   end

   assign req_stall = (state_ff != F_IDLE);
   assign job_valid = (state_ff == F_DONE);
   assign job_data  = '{mode: item_ff.mode, key: item_ff.key, value: item_ff.value,
                        bucket: rem_ff[BucketBits-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  div_ff   <= eff_count_in;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               if (shifted_in >= (KeyBits+1)'(div_ff)) begin
                  rem_ff <= KeyBits'(shifted_in - (KeyBits+1)'(div_ff));
               end else begin
                  rem_ff <= shifted_in[KeyBits-1:0];
               end
               if (32'(step_ff) == KeyBits - 1) begin
                  state_ff <= F_DONE;
               end
               step_ff <= step_ff + StepBits'(1);
            end
            F_DONE: begin
               if (!job_stall) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (rem_ff < KeyBits'(div_ff)))
      else $error("remainder not below divisor");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job_stall) |=> job_valid)
      else $error("job dropped while stalled");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_DIV) |-> (div_ff != '0))
      else $error("zero divisor");

endmodule

>>> rtl/chm_queue.sv
module chm_queue import chm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_data
);

   localparam int PtrBits = $clog2(QueueDepth);

   job_type            slot_ff [QueueDepth];
   logic [PtrBits-1:0] wr_ff, rd_ff;
   logic [PtrBits:0]   fill_ff;
   logic               push, pop;

   assign in_stall  = (32'(fill_ff) == QueueDepth);
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (32'(wr_ff) == QueueDepth - 1) ? '0 : wr_ff + PtrBits'(1);
         end
         if (pop) begin
            rd_ff <= (32'(rd_ff) == QueueDepth - 1) ? '0 : rd_ff + PtrBits'(1);
         end
         fill_ff <= fill_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end

endmodule

>>> rtl/chm_back.sv
// Chain walk and update. Heads cleared by a sweep after reset.
module chm_back import chm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_stall,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_HEAD, B_NODE, B_CHECK, B_DONE
   } bstate_type;

   bstate_type            state_ff;
   job_type               job_ff;
   logic [BucketBits-1:0] clr_ff;
   logic [RefBits-1:0]    ref_ff;
   logic [RefBits-1:0]    head_ff;
   logic [RefBits-1:0]    used_ff;
   logic [NodeBits:0]     steps_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [RefBits-1:0]    heads [Buckets];
   logic [KeyBits-1:0]    keys  [PoolNodes];
   logic [ValueBits-1:0]  vals  [PoolNodes];
   logic [RefBits-1:0]    links [PoolNodes];

   logic [RefBits-1:0]    head_rd_ff;
   logic [KeyBits-1:0]    key_rd_ff;
   logic [ValueBits-1:0]  val_rd_ff;
   logic [RefBits-1:0]    link_rd_ff;

   logic                  head_we, node_we, val_we;
   logic [BucketBits-1:0] head_wa;
   logic [RefBits-1:0]    head_wd;
   logic [NodeBits-1:0]   node_wa, node_ra;
   logic [ValueBits-1:0]  val_wd;
   logic                  full;
   logic                  check_go, hit, chain_end, ins_req, ins_ok;

   assign full      = (32'(used_ff) >= PoolNodes);
   assign job_stall = (state_ff != B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign node_ra   = NodeBits'(ref_ff - RefBits'(1));

   // the check step waits while the previous result is still held
   assign check_go  = (state_ff == B_CHECK) && !(rsp_valid_ff && rsp_stall);
   assign hit       = ref_ff != '0 && 32'(ref_ff) <= PoolNodes && key_rd_ff == job_ff.key;
   assign chain_end = ref_ff == '0 || 32'(ref_ff) > PoolNodes ||
                      32'(steps_ff) >= PoolNodes;
   assign ins_req   = (job_ff.mode == MODE_SET || job_ff.mode == MODE_TOUCH);
   assign ins_ok    = ins_req && !full;

   always_comb begin
      head_we = 1'b0;
      head_wa = clr_ff;
      head_wd = '0;
      node_we = 1'b0;
      val_we  = 1'b0;
      node_wa = used_ff[NodeBits-1:0];
      val_wd  = job_ff.value;
      if (state_ff == B_CLEAR) begin
         head_we = 1'b1;
      end else if (check_go) begin
         if (hit) begin
            val_we  = (job_ff.mode == MODE_SET);
            node_wa = node_ra;
         end else if (chain_end) begin
            if (ins_ok) begin
               node_we = 1'b1;
               val_we  = 1'b1;
               val_wd  = (job_ff.mode == MODE_SET) ? job_ff.value : '0;
               head_we = 1'b1;
               head_wa = job_ff.bucket;
               head_wd = used_ff + RefBits'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         heads[head_wa] <= head_wd;
      end
      head_rd_ff <= heads[job_data.bucket];
      if (node_we) begin
         keys[node_wa]  <= job_ff.key;
         links[node_wa] <= head_ff;
      end
      if (val_we) begin
         vals[node_wa] <= val_wd;
      end
      key_rd_ff  <= keys[node_ra];
      val_rd_ff  <= vals[node_ra];
      link_rd_ff <= links[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (check_go && (hit || chain_end)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + BucketBits'(1);
               if (32'(clr_ff) == Buckets - 1) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  steps_ff <= '0;
                  state_ff <= B_HEAD;
               end
            end
            B_HEAD: begin
               ref_ff   <= head_rd_ff;
               head_ff  <= head_rd_ff;
               state_ff <= B_NODE;
            end
            B_NODE: begin
               state_ff <= B_CHECK;
            end
            B_CHECK: begin
               if (check_go) begin
                  if (hit) begin
                     rsp_ff   <= '{found: 1'b1, value_out: val_rd_ff, pool_full: 1'b0,
                                   entry_count: 13'(used_ff)};
                     state_ff <= B_IDLE;
                  end else if (chain_end) begin
                     rsp_ff <= '{found: 1'b0, value_out: '0, pool_full: ins_req && full,
                                 entry_count: 13'(ins_ok ? used_ff + RefBits'(1)
                                                         : used_ff)};
                     if (ins_ok) begin
                        used_ff <= used_ff + RefBits'(1);
                     end
                     state_ff <= B_IDLE;
                  end else begin
                     ref_ff   <= link_rd_ff;
                     steps_ff <= steps_ff + (NodeBits+1)'(1);
                     state_ff <= B_NODE;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= PoolNodes)
      else $error("pool count overflow");
   a_full_nostore: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pool_full) |-> !rsp_data.found)
      else $error("full flag with hit");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + RefBits'(1)))
      else $error("pool count jumped");

endmodule

>>> rtl/chained_hash_map_engine_top.sv
// Chained hash map: one result item per request item, in order. The front
// takes the key modulo bucket_count bit-serially: it accepts an item, runs
// one division step per key bit and hands the item to the queue, and it
// takes a new item only after that hand-off. The back reads the bucket head
// and then reads and checks one chain link after another (a miss also
// examines the empty end link); the update is done in the check that ends
// the walk. It overlaps the next item's modulo through a two-entry queue.
// After reset the bucket heads are cleared in a sweep over all 1024 buckets
// before the first item is served.
// bucket_count 0 acts as 1, above 1024 as 1024.
module chained_hash_map_engine_top import chm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [10:0] csr_data
);

   logic [CountBits-1:0] count_ff;
   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountBits'(Buckets);
      end else if (csr_write) begin
         count_ff <= csr_data;
      end
   end

   chm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .csr_count(count_ff),
      .job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
   );

   chm_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   chm_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_stall(b_stall), .job_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

>>> tb/sv/chained_hash_map_checker.sv
module chained_hash_map_checker import chm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [10:0] csr_data,
   output int          fail_count,
   output int          pending
);

   logic [10:0]           map_buckets;
   logic [RefBits-1:0]    map_heads [Buckets];
   logic [KeyBits-1:0]    map_keys [PoolNodes];
   logic [ValueBits-1:0]  map_values [PoolNodes];
   logic [RefBits-1:0]    map_links [PoolNodes];
   logic [12:0]           map_used;
   rsp_type               lookup_results [$];

   function automatic rsp_type apply_request(req_type rq);
      rsp_type         r;
      int unsigned     nb;
      int unsigned     bkt;
      int unsigned     ref_n;
      int unsigned     steps;
      int unsigned     hit;
      r = '0;
      nb = (map_buckets == 0) ? 1 :
           (32'(map_buckets) > Buckets ? Buckets : 32'(map_buckets));
      bkt = rq.key % nb;
      ref_n = 32'(map_heads[bkt]);
      hit = 0;
      steps = 0;
      while (ref_n != 0 && steps < PoolNodes && hit == 0) begin
         if (map_keys[ref_n-1] == rq.key) hit = ref_n;
         else ref_n = 32'(map_links[ref_n-1]);
         steps++;
      end
      if (hit != 0) begin
         r.found = 1'b1;
         r.value_out = map_values[hit-1];
         if (rq.mode == MODE_SET) map_values[hit-1] = rq.value;
      end else if (rq.mode == MODE_SET || rq.mode == MODE_TOUCH) begin
         if (32'(map_used) >= PoolNodes) begin
            r.pool_full = 1'b1;
         end else begin
            map_keys[map_used] = rq.key;
            map_values[map_used] = (rq.mode == MODE_SET) ? rq.value : '0;
            map_links[map_used] = map_heads[bkt];
            map_heads[bkt] = RefBits'(map_used) + RefBits'(1);
            map_used = map_used + 13'd1;
         end
      end
      r.entry_count = map_used;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         map_buckets = 11'd1024;
         for (int i = 0; i < Buckets; i++) map_heads[i] = '0;
         map_used = '0;
         lookup_results.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_write) map_buckets = csr_data;
         if (req_valid && !req_stall) lookup_results.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (lookup_results.size() == 0) begin
               $error("result item with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = lookup_results.pop_front();
               if (e !== rsp_data) begin
                  if (e.found !== rsp_data.found)
                     $error("found: expected %0d actual %0d", e.found, rsp_data.found);
                  if (e.value_out !== rsp_data.value_out)
                     $error("value_out: expected %0h actual %0h",
                            e.value_out, rsp_data.value_out);
                  if (e.pool_full !== rsp_data.pool_full)
                     $error("pool_full: expected %0d actual %0d",
                            e.pool_full, rsp_data.pool_full);
                  if (e.entry_count !== rsp_data.entry_count)
                     $error("entry_count: expected %0d actual %0d",
                            e.entry_count, rsp_data.entry_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= lookup_results.size();
      end
   end

endmodule

>>> tb/sv/tb_chained_hash_map_engine_top.sv
module tb_chained_hash_map_engine_top;
   import chm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [10:0] csr_data = '0;
   int          fail_count;
   int          pending;
   bit          calm = 1'b0;
   bit          hold_long = 1'b0;
   logic [31:0] key_pool [16];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   chained_hash_map_engine_top i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_data
   );

   chained_hash_map_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_data,
      .fail_count, .pending
   );

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_long = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // valid stays up after the accept; a drain, or the next call when it inserts a gap, takes it down
   task automatic send_item(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: mode, key: key, value: value};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_and_set(logic [10:0] buckets);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_write <= 1'b1;
      csr_data <= buckets;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(int count, int key_span);
      logic [1:0]  m;
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         m = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 7)
            k = key_pool[$urandom_range(0, 15)] + 32'($urandom_range(0, key_span));
         else k = $urandom();
         send_item(m, k, $urandom());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'd0;
      key_pool[1] = 32'hFFFF_FFF0;
      drain_and_set(11'd0);
      // directed: extremes, every mode, lookups of absent keys
      send_item(MODE_LOOKUP, 32'd0, 32'd0);
      send_item(MODE_SET, 32'd0, 32'hFFFF_FFFF);
      send_item(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(MODE_LOOKUP, 32'd0, 32'd0);
      send_item(MODE_TOUCH, 32'd0, 32'd5);
      send_item(MODE_TOUCH, 32'h8000_0000, 32'd7);
      send_item(2'd3, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_item(MODE_SET, 32'h8000_0000, 32'h5555_AAAA);
      send_item(MODE_LOOKUP, 32'h8000_0000, 32'd0);
      send_item(2'd3, 32'h1234_5678, 32'd0);
      drain_and_set(11'd2047);
      send_item(MODE_LOOKUP, 32'd0, 32'd0);
      send_item(MODE_SET, 32'd1024, 32'd9);
      send_item(MODE_LOOKUP, 32'd1024, 32'd0);
      drain_and_set(11'd1);
      send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0);
      // long hold-off while the sender keeps offering items
      hold_long = 1'b1;
      random_phase(40, 8);
      drain_and_set(11'd3);
      random_phase(300, 16);
      drain_and_set(11'd1024);
      random_phase(400, 64);
      drain_and_set(11'd37);
      random_phase(300, 32);
      drain_and_set(11'd1000);
      // a run of fresh keys
      for (int i = 0; i < 400; i++) send_item(MODE_TOUCH, 32'h4000_0000 + 32'(i), 32'd0);
      random_phase(300, 64);
      drain_and_set(11'd512);
      calm = 1'b1;
      random_phase(300, 64);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("tb_chained_hash_map_engine_top passed");
      else $display("tb_chained_hash_map_engine_top failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_chained_hash_map_engine_top failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/chm_pkg.sv
rtl/chm_front.sv
rtl/chm_queue.sv
rtl/chm_back.sv
rtl/chained_hash_map_engine_top.sv
tb/sv/chained_hash_map_checker.sv
tb/sv/tb_chained_hash_map_engine_top.sv
